// ----- rtl/wfs_pkg.sv -----
// Shared types, constants and helper functions for the winnowing fingerprint stream.
// Used by the hash cells, the window cells and the top level; depends on nothing.
`default_nettype none

package wfs_pkg;

  // Sizing of the k-gram chain, the window chain and the position counter.
  localparam int MAX_KGRAM  = 64;
  localparam int MAX_WINDOW = 64;
  localparam int POS_WIDTH  = 32;

  localparam int K_W    = $clog2(MAX_KGRAM + 1);
  localparam int KIDX_W = (MAX_KGRAM > 1) ? $clog2(MAX_KGRAM) : 1;
  localparam int W_W    = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // Register reset values and register indexes on the configuration port.
  localparam logic [6:0] KGRAM_RESET     = 7'd5;
  localparam logic [6:0] GUARANTEE_RESET = 7'd8;
  localparam logic       REG_KGRAM       = 1'b0;
  localparam logic       REG_GUARANTEE   = 1'b1;

  typedef logic [31:0]          hash_t;
  typedef logic [POS_WIDTH-1:0] pos_t;

  localparam pos_t POS_MAX = '1;

  // One window entry: a k-gram hash and the start position of its k-gram.
  typedef struct packed {
    hash_t hash;
    pos_t  pos;
  } win_entry_t;

  // Control for the hash cell row.
  typedef struct packed {
    logic shift;
    logic clear;
  } hash_ctrl_t;

  // Control for the window cell row.
  typedef struct packed {
    logic push;
    logic rotate;
  } win_ctrl_t;

  // Multiply by the hash base 31 with a shift and a subtract, modulo 2^32.
  function automatic hash_t times31(hash_t h);
    return (h << 5) - h;
  endfunction

  // Effective k-gram length, clamped to 1..MAX_KGRAM.
  function automatic logic [K_W-1:0] effective_k(logic [6:0] kreg);
    int k;
    k = int'(kreg);
    if (k < 1) k = 1;
    if (k > MAX_KGRAM) k = MAX_KGRAM;
    return K_W'(k);
  endfunction

  // Effective window size max(1, t - k + 1), clamped to MAX_WINDOW.
  function automatic logic [W_W-1:0] effective_w(logic [6:0] treg, logic [K_W-1:0] k);
    int w;
    w = int'(treg) - int'(k) + 1;
    if (w < 1) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    return W_W'(w);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wfs_hash_cell.sv -----
// One cell of the hash row: holds the polynomial hash of the newest L bytes.
// Depends on wfs_pkg; takes the hash of the newest L-1 bytes from its left neighbor.
`default_nettype none

module wfs_hash_cell (
  input  logic               clk,
  input  logic               rst,
  input  wfs_pkg::hash_ctrl_t ctrl,
  input  wfs_pkg::hash_t     prev_hash,
  input  logic [7:0]         text_byte,
  output wfs_pkg::hash_t     hash
);
  import wfs_pkg::*;

  hash_t hash_next;

  // A new text starts from an all-zero history, so the neighbor counts as zero.
  always_comb begin
    if (ctrl.clear) begin
      hash_next = hash_t'(text_byte);
    end else begin
      hash_next = times31(prev_hash) + hash_t'(text_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (ctrl.shift) begin
      hash <= hash_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wfs_window_cell.sv -----
// One cell of the window row: holds one k-gram hash and its start position.
// Depends on wfs_pkg; shifts toward older entries on a push and rotates on a scan step.
`default_nettype none

module wfs_window_cell (
  input  logic                clk,
  input  wfs_pkg::win_ctrl_t  ctrl,
  input  wfs_pkg::win_entry_t newer_in,
  input  wfs_pkg::win_entry_t older_in,
  output wfs_pkg::win_entry_t entry
);
  import wfs_pkg::*;

  // A push takes the newer neighbor's entry; a scan step takes the older one.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= newer_in;
    end else if (ctrl.rotate) begin
      entry <= older_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/winnowing_fingerprint_stream.sv -----
// Top level of the winnowing fingerprint stream: configuration registers, sequencer,
// hash cell row, window cell row and output register. Depends on wfs_pkg and both cells.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  text_byte, new_text
//   out      output     out_valid / out_stall fp_hash, fp_position
//   cfg      input      APB psel / penable   paddr, pwdata, prdata (kgram_len, guarantee_len)
//
// A byte passes only the push state while no full window exists, else also the scan
// and emit states: the window row rotates once past the single minimum comparator.
// A pending result waits in the output register; a second result waits for it.
// Reset is synchronous and clears the registers, hash cells and counters; the window
// row is not cleared, since the fill count keeps unwritten entries out of every scan.
`default_nettype none

module winnowing_fingerprint_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  text_byte,
  input  logic        new_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] fp_hash,
  output logic [31:0] fp_position,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wfs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PUSH = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [6:0]       kgram_len, guarantee_len;
  logic [K_W-1:0]   eff_k;
  logic [W_W-1:0]   eff_w;
  pos_t             byte_count, count_base;
  logic [W_W-1:0]   fill, fill_inc;
  logic [IDX_W-1:0] scan_idx;
  win_entry_t       best, new_entry;
  pos_t             last_pos;
  logic             emitted_any;
  logic             in_accept, cfg_write, kgram_ok, fire_ok, out_load;
  hash_ctrl_t       hash_ctrl;
  win_ctrl_t        win_ctrl;
  hash_t            hash_row [MAX_KGRAM];
  win_entry_t       win_row [MAX_WINDOW];

  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_WINDOW - 1);

  // Configuration port: always ready, one register per word.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kgram_len     <= KGRAM_RESET;
      guarantee_len <= GUARANTEE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_KGRAM:     kgram_len     <= pwdata[6:0];
        REG_GUARANTEE: guarantee_len <= pwdata[6:0];
        default:       kgram_len     <= kgram_len;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_KGRAM:     prdata = {25'd0, kgram_len};
      REG_GUARANTEE: prdata = {25'd0, guarantee_len};
      default:       prdata = '0;
    endcase
  end

  assign eff_k = effective_k(kgram_len);
  assign eff_w = effective_w(guarantee_len, eff_k);

  // Input transfer and cell control.
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign hash_ctrl.shift = in_accept;
  assign hash_ctrl.clear = new_text;

  // Hash row: cell L-1 holds the hash of the newest L bytes.
  for (genvar i = 0; i < MAX_KGRAM; i++) begin : g_hash
    hash_t prev_hash;
    if (i == 0) begin : g_first
      assign prev_hash = '0;
    end else begin : g_rest
      assign prev_hash = hash_row[i-1];
    end
    wfs_hash_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (hash_ctrl),
      .prev_hash (prev_hash),
      .text_byte (text_byte),
      .hash      (hash_row[i])
    );
  end

  // New window entry, formed in the cycle after the byte transfer.
  assign kgram_ok       = (byte_count >= POS_WIDTH'(eff_k));
  assign new_entry.hash = hash_row[KIDX_W'(eff_k - 1'b1)];
  assign new_entry.pos  = byte_count - POS_WIDTH'(eff_k);
  assign fill_inc       = (fill == W_W'(MAX_WINDOW)) ? fill : fill + 1'b1;

  assign win_ctrl.push   = (state == ST_PUSH) && kgram_ok;
  assign win_ctrl.rotate = (state == ST_SCAN);

  // Window row: entry 0 is the newest; a scan rotates entry s into cell 0 at step s.
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_win
    win_entry_t newer_in, older_in;
    if (i == 0) begin : g_first
      assign newer_in = new_entry;
    end else begin : g_rest
      assign newer_in = win_row[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_last
      assign older_in = win_row[0];
    end else begin : g_mid
      assign older_in = win_row[i+1];
    end
    wfs_window_cell u_cell (
      .clk      (clk),
      .ctrl     (win_ctrl),
      .newer_in (newer_in),
      .older_in (older_in),
      .entry    (win_row[i])
    );
  end

  // A result goes out when its position differs from the last one sent in this text.
  assign fire_ok  = !emitted_any || (best.pos != last_pos);
  assign out_load = (state == ST_EMIT) && fire_ok && (!out_valid || !out_stall);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept) state_next = ST_PUSH;
      ST_PUSH: begin
        if (kgram_ok && (fill_inc >= eff_w)) state_next = ST_SCAN;
        else state_next = ST_IDLE;
      end
      ST_SCAN: if (scan_idx == SCAN_LAST) state_next = ST_EMIT;
      ST_EMIT: if (!fire_ok || out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign count_base = new_text ? '0 : byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      byte_count  <= '0;
      fill        <= '0;
      scan_idx    <= '0;
      last_pos    <= '0;
      emitted_any <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      // Byte transfer: restart the text if asked, count the byte, saturating.
      if (in_accept) begin
        byte_count <= (count_base == POS_MAX) ? count_base : count_base + 1'b1;
        if (new_text) begin
          fill        <= '0;
          last_pos    <= '0;
          emitted_any <= 1'b0;
        end
      end

      if (win_ctrl.push) fill <= fill_inc;

      if (state == ST_SCAN) scan_idx <= scan_idx + 1'b1;
      else scan_idx <= '0;

      if (out_load) begin
        emitted_any <= 1'b1;
        last_pos    <= best.pos;
      end

      // Output register.
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Rightmost minimum: a strict compare keeps the newest of equal hashes.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      if ((scan_idx == '0) ||
          ((W_W'(scan_idx) < eff_w) && (win_row[0].hash < best.hash))) begin
        best <= win_row[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fp_hash     <= best.hash;
      fp_position <= 32'(best.pos);
    end
  end

`ifndef SYNTHESIS
  a_accept_to_push: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_PUSH))
    else $error("byte transfer not followed by the push step");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (scan_idx == SCAN_LAST) |=> (state == ST_EMIT))
    else $error("window scan did not end after a full rotation");

  a_emit_records: assert property (@(posedge clk) disable iff (rst)
    out_load |=> emitted_any && out_valid && (last_pos == $past(best.pos)))
    else $error("sent position not recorded");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= W_W'(MAX_WINDOW))
    else $error("window fill count out of range");

  a_scan_needs_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) && (state_next == ST_SCAN) |-> kgram_ok && (fill_inc >= eff_w))
    else $error("scan started without a full window");
`endif

endmodule

`default_nettype wire
